### hw/rtl/fcar_pkg.sv
// Shared widths, register indexes and limits for the frame co-adding averager.
`default_nettype none
package fcar_pkg;
    localparam int ADDR_W   = 16;
    localparam int PIXEL_W  = 16;
    localparam int SUM_W    = 27;
    localparam int SQ_W     = 41;
    localparam int DIV_W    = 41;
    localparam int DEN_W    = 11;
    localparam int ROOT_W   = 21;
    localparam int CFG_W    = 17;
    localparam int NPIX_W   = 17;
    localparam int FRAMES_MAX = 1024;
    localparam int PIXELS_MAX = 65536;

    localparam logic [1:0] REG_FRAMES = 2'd0;
    localparam logic [1:0] REG_AVG_EN = 2'd1;
    localparam logic [1:0] REG_RMS_EN = 2'd2;
    localparam logic [1:0] REG_NPIX   = 2'd3;
endpackage
`default_nettype wire

### hw/rtl/fcar_mem.sv
// Per-pixel sum and sum-of-squares memories with a registered read port.
`default_nettype none
module fcar_mem (
    input  wire logic                         i_clk,
    input  wire logic [fcar_pkg::ADDR_W-1:0]  i_rd_addr,
    input  wire logic [fcar_pkg::ADDR_W-1:0]  i_wr_addr,
    input  wire logic                         i_sum_we,
    input  wire logic [fcar_pkg::SUM_W-1:0]   i_sum_wdata,
    input  wire logic                         i_sq_we,
    input  wire logic [fcar_pkg::SQ_W-1:0]    i_sq_wdata,
    output logic      [fcar_pkg::SUM_W-1:0]   o_sum_rdata,
    output logic      [fcar_pkg::SQ_W-1:0]    o_sq_rdata
);
    logic [fcar_pkg::SUM_W-1:0] r_sum_mem [fcar_pkg::PIXELS_MAX];
    logic [fcar_pkg::SQ_W-1:0]  r_sq_mem  [fcar_pkg::PIXELS_MAX];

    always_ff @(posedge i_clk) begin
        if (i_sum_we) begin
            r_sum_mem[i_wr_addr] <= i_sum_wdata;
        end
        o_sum_rdata <= r_sum_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_sq_we) begin
            r_sq_mem[i_wr_addr] <= i_sq_wdata;
        end
        o_sq_rdata <= r_sq_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

### hw/rtl/fcar_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none
module fcar_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [fcar_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [fcar_pkg::DEN_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic      [fcar_pkg::DIV_W-1:0]  o_quotient
);
    logic                          r_busy;
    logic [5:0]                    r_cnt;
    logic [fcar_pkg::DEN_W-1:0]    r_den;
    logic [fcar_pkg::DEN_W-1:0]    r_rem;
    logic [fcar_pkg::DEN_W:0]      n_shift;
    logic                          n_ge;

    assign n_shift = {r_rem, o_quotient[fcar_pkg::DIV_W-1]};
    assign n_ge    = n_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_cnt      <= 6'(fcar_pkg::DIV_W - 1);
                r_den      <= i_divisor;
                r_rem      <= '0;
                o_quotient <= i_dividend;
            end else if (r_busy) begin
                r_rem      <= n_ge ? fcar_pkg::DEN_W'(n_shift - {1'b0, r_den})
                                   : fcar_pkg::DEN_W'(n_shift);
                o_quotient <= {o_quotient[fcar_pkg::DIV_W-2:0], n_ge};
                r_cnt      <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/fcar_sqrt.sv
// Iterative floor square root that settles one root bit per cycle.
`default_nettype none
module fcar_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [fcar_pkg::DIV_W-1:0]   i_value,
    output logic                              o_done,
    output logic      [fcar_pkg::ROOT_W-1:0]  o_root
);
    logic                         r_busy;
    logic [fcar_pkg::DIV_W-1:0]   r_x;
    logic [fcar_pkg::DIV_W-1:0]   r_bit;
    logic [fcar_pkg::DIV_W-1:0]   r_root;
    logic [fcar_pkg::DIV_W:0]     n_trial;

    assign n_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign o_root  = r_root[fcar_pkg::ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_value;
                r_bit  <= {1'b1, {(fcar_pkg::DIV_W - 1){1'b0}}};
                r_root <= '0;
            end else if (r_busy) begin
                if ({1'b0, r_x} >= n_trial) begin
                    r_x    <= fcar_pkg::DIV_W'({1'b0, r_x} - n_trial);
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[1:0] != 2'b00) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/frame_coadd_average_rms.sv
// Top level of the frame co-adding averager with per-pixel mean and RMS.
// Pixels arrive on the input channel (i_valid, o_stall, i_pixel_value) in
// raster order, frame after frame. Each pixel position keeps a running sum
// and, when RMS is enabled, a running sum of squares in on-chip memory.
// On the last frame of a group, with the mean or the RMS enabled, each pixel
// produces one result transfer on the output channel (o_valid, i_stall)
// with the mean, the RMS, their valid flags and a last-pixel-of-frame flag.
// A pixel that produces no result passes through one memory read and one
// write back. A pixel of a group's last frame goes on through the two
// bit-serial dividers, run side by side, then the bit-serial square root.
// One pixel is processed at a time; o_stall is low only while idle.
// The output register holds a result until it is taken, so the next pixel
// is accepted while a result waits; that pixel's result waits in turn while
// i_stall is high. Reset clears the pixel position and frame counter and
// loads the register defaults; the memories are not cleared, since the
// first frame of every group overwrites them.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data; the
// user must write them only while the block is idle, which it does not enforce.
`default_nettype none
module frame_coadd_average_rms (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [fcar_pkg::PIXEL_W-1:0] i_pixel_value,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [fcar_pkg::PIXEL_W-1:0] o_mean_value,
    output logic                                o_mean_valid,
    output logic        [fcar_pkg::PIXEL_W-1:0] o_rms_value,
    output logic                                o_rms_valid,
    output logic                                o_frame_last,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [fcar_pkg::CFG_W-1:0]     i_cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_UPD, S_DIV, S_SQRT, S_OUT} t_state;

    t_state                          r_state;
    logic [fcar_pkg::DEN_W-1:0]      r_frames_cfg;
    logic                            r_avg_en;
    logic                            r_rms_en;
    logic [fcar_pkg::NPIX_W-1:0]     r_npix_cfg;
    logic [fcar_pkg::ADDR_W-1:0]     r_pos;
    logic [fcar_pkg::DEN_W-1:0]      r_fd;
    logic [fcar_pkg::ADDR_W-1:0]     r_idx;
    logic signed [fcar_pkg::PIXEL_W-1:0] r_pix;
    logic [31:0]                     r_sq;
    logic                            r_first;
    logic                            r_emit;
    logic                            r_lastpix;
    logic [fcar_pkg::DEN_W-1:0]      r_count;
    logic                            r_mean_neg;

    logic [fcar_pkg::DEN_W-1:0]      n_nfr;
    logic [fcar_pkg::NPIX_W-1:0]     n_npix;
    logic [fcar_pkg::DEN_W-1:0]      n_count;
    logic                            n_last_frame;
    logic                            n_last_pixel;
    logic                            n_accept;
    logic [fcar_pkg::SUM_W-1:0]      n_sum;
    logic [fcar_pkg::SQ_W-1:0]       n_sqsum;
    logic [fcar_pkg::SUM_W-1:0]      n_mag;
    logic [fcar_pkg::SUM_W-1:0]      sum_rd;
    logic [fcar_pkg::SQ_W-1:0]       sq_rd;
    logic                            div_sum_done;
    logic                            div_sq_done;
    logic [fcar_pkg::DIV_W-1:0]      q_sum;
    logic [fcar_pkg::DIV_W-1:0]      q_sq;
    logic                            sqrt_done;
    logic [fcar_pkg::ROOT_W-1:0]     root;
    logic signed [fcar_pkg::PIXEL_W-1:0] n_mean;
    logic [fcar_pkg::PIXEL_W-1:0]    n_rms;
    logic                            n_out_free;
    logic                            upd;

    assign o_stall  = (r_state != S_IDLE);
    assign n_accept = i_valid && !o_stall;
    assign upd      = (r_state == S_UPD);

    always_comb begin
        if (r_frames_cfg == '0) begin
            n_nfr = fcar_pkg::DEN_W'(1);
        end else if (r_frames_cfg > fcar_pkg::DEN_W'(fcar_pkg::FRAMES_MAX)) begin
            n_nfr = fcar_pkg::DEN_W'(fcar_pkg::FRAMES_MAX);
        end else begin
            n_nfr = r_frames_cfg;
        end
        if (r_npix_cfg == '0) begin
            n_npix = fcar_pkg::NPIX_W'(1);
        end else if (r_npix_cfg > fcar_pkg::NPIX_W'(fcar_pkg::PIXELS_MAX)) begin
            n_npix = fcar_pkg::NPIX_W'(fcar_pkg::PIXELS_MAX);
        end else begin
            n_npix = r_npix_cfg;
        end
    end

    assign n_count      = r_fd + fcar_pkg::DEN_W'(1);
    assign n_last_frame = n_count >= n_nfr;
    assign n_last_pixel = ({1'b0, r_pos} + fcar_pkg::NPIX_W'(1)) >= n_npix;

    assign n_sum   = (r_first ? '0 : sum_rd)
                   + {{(fcar_pkg::SUM_W - fcar_pkg::PIXEL_W){r_pix[fcar_pkg::PIXEL_W-1]}},
                      r_pix};
    assign n_sqsum = (r_first ? '0 : sq_rd) + {9'd0, r_sq};
    assign n_mag   = n_sum[fcar_pkg::SUM_W-1] ? (~n_sum + fcar_pkg::SUM_W'(1)) : n_sum;

    fcar_mem u_mem (
        .i_clk       (i_clk),
        .i_rd_addr   (r_pos),
        .i_wr_addr   (r_idx),
        .i_sum_we    (upd),
        .i_sum_wdata (n_sum),
        .i_sq_we     (upd && r_rms_en),
        .i_sq_wdata  (n_sqsum),
        .o_sum_rdata (sum_rd),
        .o_sq_rdata  (sq_rd)
    );

    fcar_div u_div_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (upd && r_emit),
        .i_dividend ({{(fcar_pkg::DIV_W - fcar_pkg::SUM_W){1'b0}}, n_mag}),
        .i_divisor  (r_count),
        .o_done     (div_sum_done),
        .o_quotient (q_sum)
    );

    fcar_div u_div_sq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (upd && r_emit),
        .i_dividend (r_rms_en ? n_sqsum : '0),
        .i_divisor  (r_count),
        .o_done     (div_sq_done),
        .o_quotient (q_sq)
    );

    fcar_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_sq_done),
        .i_value (q_sq),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    always_comb begin
        if (!r_avg_en) begin
            n_mean = '0;
        end else if (r_mean_neg) begin
            n_mean = (q_sum > fcar_pkg::DIV_W'(32768)) ? 16'sh8000
                   : fcar_pkg::PIXEL_W'(~q_sum + fcar_pkg::DIV_W'(1));
        end else begin
            n_mean = (q_sum > fcar_pkg::DIV_W'(32767)) ? 16'sh7FFF
                   : fcar_pkg::PIXEL_W'(q_sum);
        end
        if (!r_rms_en) begin
            n_rms = '0;
        end else if (root > fcar_pkg::ROOT_W'(32768)) begin
            n_rms = 16'h8000;
        end else begin
            n_rms = fcar_pkg::PIXEL_W'(root);
        end
    end

    assign n_out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_cfg <= fcar_pkg::DEN_W'(16);
            r_avg_en     <= 1'b1;
            r_rms_en     <= 1'b0;
            r_npix_cfg   <= fcar_pkg::NPIX_W'(fcar_pkg::PIXELS_MAX);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fcar_pkg::REG_FRAMES: r_frames_cfg <= i_cfg_data[fcar_pkg::DEN_W-1:0];
                fcar_pkg::REG_AVG_EN: r_avg_en     <= i_cfg_data[0];
                fcar_pkg::REG_RMS_EN: r_rms_en     <= i_cfg_data[0];
                fcar_pkg::REG_NPIX:   r_npix_cfg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_fd    <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_idx     <= r_pos;
                        r_pix     <= i_pixel_value;
                        r_sq      <= 32'(i_pixel_value * i_pixel_value);
                        r_first   <= (r_fd == '0);
                        r_count   <= n_count;
                        r_emit    <= n_last_frame && (r_avg_en || r_rms_en);
                        r_lastpix <= n_last_pixel;
                        if (n_last_pixel) begin
                            r_pos <= '0;
                            r_fd  <= n_last_frame ? '0 : n_count;
                        end else begin
                            r_pos <= r_pos + fcar_pkg::ADDR_W'(1);
                        end
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_mean_neg <= n_sum[fcar_pkg::SUM_W-1];
                    r_state    <= r_emit ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    if (div_sq_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_out_free) begin
                        o_valid      <= 1'b1;
                        o_mean_value <= n_mean;
                        o_mean_valid <= r_avg_en;
                        o_rms_value  <= n_rms;
                        o_rms_valid  <= r_rms_en;
                        o_frame_last <= r_lastpix;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> r_state == S_UPD)
        else $error("accepted pixel did not move to the update step");

    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sum_done == div_sq_done)
        else $error("dividers finished out of step");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sq_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide step");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("result transfer raised outside the output step");
endmodule
`default_nettype wire

### tb/sv/tb_frame_coadd_average_rms.sv
// Self-checking testbench for the frame co-adding averager with per-pixel mean and RMS.
`timescale 1ns / 100ps
module tb_frame_coadd_average_rms;
    import fcar_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic signed [PIXEL_W-1:0] mean;
        logic                      mean_ok;
        logic        [PIXEL_W-1:0] rms;
        logic                      rms_ok;
        logic                      frame_last;
    } pixel_result_t;

    typedef struct {
        bit                        is_reg;
        logic [1:0]                idx;
        logic [CFG_W-1:0]          data;
        logic signed [PIXEL_W-1:0] pixel;
        bit                        typed;
        pixel_result_t             want;
    } stim_row_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [PIXEL_W-1:0] i_pixel_value;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [PIXEL_W-1:0] o_mean_value;
    logic                      o_mean_valid;
    logic        [PIXEL_W-1:0] o_rms_value;
    logic                      o_rms_valid;
    logic                      o_frame_last;
    logic                      i_cfg_we;
    logic [1:0]                i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;

    frame_coadd_average_rms i_dut (.*);

    logic signed [SUM_W-1:0] sum_mem [PIXELS_MAX];
    logic        [SQ_W-1:0]  sq_mem  [PIXELS_MAX];
    int unsigned             pix_pos;
    int unsigned             frames_done;
    int unsigned             frames_cfg;
    bit                      avg_on;
    bit                      rms_on;
    int unsigned             npix_cfg;

    pixel_result_t expected_results [$];
    stim_row_t     directed_rows [$];
    bit            failed;
    bit            in_take;
    bit            out_take;
    pixel_result_t out_seen;
    int            pixels_sent;
    bit            calm;
    int            hold_req;
    int            hold_seen;
    int            hold_left;
    int            quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'h1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit coadd_pixel(input logic signed [PIXEL_W-1:0] v,
                                       output pixel_result_t r);
        int unsigned     nf;
        int unsigned     np;
        longint signed   sv;
        longint signed   s;
        longint signed   mean;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned cnt;
        longint unsigned rt;
        bit              lf;
        bit              lp;
        bit              has;
        nf = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES_MAX) ? FRAMES_MAX : frames_cfg);
        np = (npix_cfg == 0) ? 1 : ((npix_cfg > PIXELS_MAX) ? PIXELS_MAX : npix_cfg);
        sv = v;
        mag = (sv < 0) ? -sv : sv;
        sq = mag * mag;
        if (frames_done == 0) begin
            sum_mem[pix_pos] = sv[SUM_W-1:0];
            if (rms_on) sq_mem[pix_pos] = sq[SQ_W-1:0];
        end else begin
            sum_mem[pix_pos] = sum_mem[pix_pos] + sv[SUM_W-1:0];
            if (rms_on) sq_mem[pix_pos] = sq_mem[pix_pos] + sq[SQ_W-1:0];
        end
        cnt = frames_done + 1;
        lf = cnt >= nf;
        lp = pix_pos + 1 >= np;
        r = '0;
        has = lf && (avg_on || rms_on);
        if (has) begin
            if (avg_on) begin
                s = sum_mem[pix_pos];
                mean = s / longint'(cnt);
                if (mean > 32767) mean = 32767;
                if (mean < -32768) mean = -32768;
                r.mean = mean[PIXEL_W-1:0];
                r.mean_ok = 1'b1;
            end
            if (rms_on) begin
                rt = floor_root(sq_mem[pix_pos] / cnt);
                if (rt > 32768) rt = 32768;
                r.rms = rt[PIXEL_W-1:0];
                r.rms_ok = 1'b1;
            end
            r.frame_last = lp;
        end
        if (lp) begin
            pix_pos = 0;
            frames_done = lf ? 0 : cnt;
        end else begin
            pix_pos++;
        end
        return has;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FRAMES: frames_cfg = data & 17'h7FF;
            REG_AVG_EN: avg_on = data[0];
            REG_RMS_EN: rms_on = data[0];
            REG_NPIX:   npix_cfg = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drains every outstanding result, then lets any result-free pixel finish.
    task automatic drain_block();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic signed [PIXEL_W-1:0] v, input bit typed,
                              input pixel_result_t want);
        pixel_result_t r;
        if (!calm && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_value <= v;
        do @(posedge i_clk); while (!in_take);
        pixels_sent++;
        if (coadd_pixel(v, r)) expected_results.push_back(typed ? want : r);
    endtask

    function automatic logic signed [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        stim_row_t row;
        row = '{is_reg: 1'b1, idx: idx, data: data, pixel: '0, typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    task automatic add_pix(input logic signed [PIXEL_W-1:0] v, input bit typed,
                           input pixel_result_t want);
        stim_row_t row;
        row = '{is_reg: 1'b0, idx: '0, data: '0, pixel: v, typed: typed, want: want};
        directed_rows.push_back(row);
    endtask

    always @(negedge i_clk) begin
        in_take  <= i_valid && !o_stall;
        out_take <= o_valid && !i_stall;
        out_seen <= '{o_mean_value, o_mean_valid, o_rms_value, o_rms_valid, o_frame_last};
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 8);
        end
    end

    always @(posedge i_clk) begin
        pixel_result_t want;
        if (i_rst_n && out_take) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transfer mean=%0d rms=%0d", $time,
                         out_seen.mean, out_seen.rms);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                if (want.mean !== out_seen.mean || want.mean_ok !== out_seen.mean_ok ||
                    want.rms !== out_seen.rms || want.rms_ok !== out_seen.rms_ok ||
                    want.frame_last !== out_seen.frame_last) begin
                    $display("%0t: mismatch expected mean=%0d/%b rms=%0d/%b last=%b",
                             $time, want.mean, want.mean_ok, want.rms, want.rms_ok,
                             want.frame_last);
                    $display("%0t:          actual mean=%0d/%b rms=%0d/%b last=%b",
                             $time, out_seen.mean, out_seen.mean_ok, out_seen.rms,
                             out_seen.rms_ok, out_seen.frame_last);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_take || out_take) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pixel_result_t none;
        int            groups;
        int            count;
        bit            held;
        none = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pixel_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_take = 1'b0;
        out_take = 1'b0;
        quiet_cycles = 0;
        hold_req = 0;
        failed = 1'b0;
        pixels_sent = 0;
        calm = 1'b0;
        held = 1'b0;
        pix_pos = 0;
        frames_done = 0;
        frames_cfg = 16;
        avg_on = 1'b1;
        rms_on = 1'b0;
        npix_cfg = PIXELS_MAX;

        add_reg(REG_FRAMES, 17'd1);
        add_reg(REG_AVG_EN, 17'd1);
        add_reg(REG_RMS_EN, 17'd1);
        add_reg(REG_NPIX, 17'd4);
        add_pix(16'sh7FFF, 1'b1, '{16'sh7FFF, 1'b1, 16'd32767, 1'b1, 1'b0});
        add_pix(16'sh8000, 1'b1, '{16'sh8000, 1'b1, 16'd32768, 1'b1, 1'b0});
        add_pix(16'sh0000, 1'b1, '{16'sh0000, 1'b1, 16'd0, 1'b1, 1'b0});
        add_pix(-16'sd1, 1'b1, '{-16'sd1, 1'b1, 16'd1, 1'b1, 1'b1});
        // A zero frame count and a zero frame size both act as one.
        add_reg(REG_FRAMES, 17'd0);
        add_reg(REG_AVG_EN, 17'd0);
        add_reg(REG_NPIX, 17'd0);
        add_pix(16'sd5, 1'b1, '{16'sd0, 1'b0, 16'd5, 1'b1, 1'b1});
        add_pix(-16'sd7, 1'b1, '{16'sd0, 1'b0, 16'd7, 1'b1, 1'b1});
        add_reg(REG_RMS_EN, 17'd0);
        add_pix(16'sd3, 1'b0, none);
        add_reg(REG_FRAMES, 17'd2);
        add_reg(REG_AVG_EN, 17'd1);
        add_reg(REG_RMS_EN, 17'd1);
        add_reg(REG_NPIX, 17'd2);
        add_pix(16'sh7FFF, 1'b0, none);
        add_pix(16'sh7FFF, 1'b0, none);
        add_pix(16'sh7FFF, 1'b0, none);
        add_pix(16'sh8000, 1'b0, none);
        // An oversized frame is cut short by lowering the frame size mid-frame.
        add_reg(REG_FRAMES, 17'd1);
        add_reg(REG_NPIX, 17'h1FFFF);
        add_pix(16'sd100, 1'b0, none);
        add_pix(-16'sd100, 1'b0, none);
        add_pix(16'sd7, 1'b0, none);
        add_reg(REG_NPIX, 17'd4);
        add_pix(16'sd9, 1'b1, '{16'sd9, 1'b1, 16'd9, 1'b1, 1'b1});
        // Lowering the frame count mid-group ends the group at once.
        add_reg(REG_FRAMES, 17'd3);
        add_reg(REG_NPIX, 17'd2);
        add_pix(16'sd10, 1'b0, none);
        add_pix(16'sd20, 1'b0, none);
        add_pix(16'sd30, 1'b0, none);
        add_reg(REG_FRAMES, 17'd2);
        add_pix(16'sd40, 1'b0, none);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_reg) begin
                drain_block();
                write_reg(directed_rows[k].idx, directed_rows[k].data);
            end else begin
                send_pixel(directed_rows[k].pixel, directed_rows[k].typed,
                           directed_rows[k].want);
            end
        end

        while (pixels_sent < 750) begin
            drain_block();
            write_reg(REG_FRAMES, {6'($urandom), ($urandom_range(9) < 8) ?
                      11'($urandom_range(0, 4)) : 11'($urandom_range(5, 20))});
            write_reg(REG_NPIX, ($urandom_range(9) < 9) ? 17'($urandom_range(0, 8)) :
                      17'($urandom_range(9, 48)));
            if ($urandom_range(9) == 0) begin
                write_reg(REG_AVG_EN, {16'($urandom), 1'b0});
                write_reg(REG_RMS_EN, {16'($urandom), 1'b0});
            end else begin
                write_reg(REG_AVG_EN, 17'($urandom));
                write_reg(REG_RMS_EN, avg_on ? 17'($urandom) : {16'($urandom), 1'b1});
            end
            groups = $urandom_range(1, 3);
            count = 0;
            while (count < groups) begin
                calm = (pixels_sent >= 200) && (pixels_sent < 350);
                if (!held && pixels_sent >= 100 && (avg_on || rms_on)) begin
                    held = 1'b1;
                    hold_req++;
                end
                send_pixel(pick_pixel(), 1'b0, none);
                if (pix_pos == 0 && frames_done == 0) count++;
            end
        end

        drain_block();
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/fcar_pkg.sv
hw/rtl/fcar_mem.sv
hw/rtl/fcar_div.sv
hw/rtl/fcar_sqrt.sv
hw/rtl/frame_coadd_average_rms.sv
tb/sv/tb_frame_coadd_average_rms.sv
